@@ design/periodic_alarm_timer_table_core_defines.svh @@
// assertion macros for the alarm timer table rtl
`ifndef PERIODIC_ALARM_TIMER_TABLE_CORE_DEFINES_SVH
`define PERIODIC_ALARM_TIMER_TABLE_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define PATT_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("patt assertion failed");

`define PATT_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("patt assertion failed");

`define PATT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("patt assertion failed");

`else

`define PATT_ASSERT_NEVER(lbl, clk, rstn, expr)
`define PATT_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define PATT_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

@@ design/patt_pkg.sv @@
// types, constants and helpers for the alarm timer table
package patt_pkg;

  localparam int SLOTS       = 16;
  localparam int MAX_RESULTS = 16;
  localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int TIME_W      = 40;
  localparam int PERIOD_W    = 32;
  localparam int CYC_W       = 16;
  localparam int CLIENT_W    = 8;
  localparam int TAG_W       = 16;

  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_DELAY  = 3'd1,
    CMD_CLOCK  = 3'd2,
    CMD_WAKEUP = 3'd3,
    CMD_FLUSH  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_ALARM  = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_FULL   = 2'd2
  } kind_e;

  typedef struct packed {
    logic [2:0]            command;
    logic [CLIENT_W-1:0]   client_id;
    logic [PERIOD_W-1:0]   delay_ticks;
    logic [CYC_W-1:0]      repeat_count;
    logic [TIME_W-1:0]     wake_time;
    logic [TAG_W-1:0]      tag;
  } req_t;

  typedef struct packed {
    logic [1:0]            kind;
    logic [CLIENT_W-1:0]   alarm_client;
    logic [TAG_W-1:0]      alarm_tag;
    logic                  last;
  } res_t;

  // controller to datapath commands
  typedef struct packed {
    logic             latch;
    logic             tick_inc;
    logic             scan;
    logic             drain;
    logic             req;
    logic             flush;
    logic [IDX_W-1:0] idx;
  } ctl_t;

  // time plus period, saturating at the largest time
  function automatic logic [TIME_W-1:0] time_add_sat(input logic [TIME_W-1:0]   t,
                                                     input logic [PERIOD_W-1:0] p);
    logic [TIME_W:0] s;
    s = {1'b0, t} + {{(TIME_W + 1 - PERIOD_W){1'b0}}, p};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

endpackage

@@ design/patt_ctrl.sv @@
// sequencer for the alarm timer table: accept, slot scan, drain, request, flush
module patt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic [2:0]         command_i,
  output logic               busy,
  output patt_pkg::ctl_t     ctl_o
);
  import patt_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_REQ,
    ST_FLUSH
  } state_e;

  state_e           state_q;
  logic [IDX_W-1:0] idx_q;
  logic             accept;

  assign accept = start && (state_q == ST_IDLE);
  assign busy   = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          idx_q <= '0;
          if (start) begin
            case (command_i)
              CMD_TICK:                          state_q <= ST_SCAN;
              CMD_DELAY, CMD_CLOCK, CMD_WAKEUP:  state_q <= ST_REQ;
              CMD_FLUSH:                         state_q <= ST_FLUSH;
              default:                           state_q <= ST_IDLE;
            endcase
          end
        end
        ST_SCAN: begin
          if (idx_q == IDX_W'(SLOTS - 1)) begin
            state_q <= ST_DRAIN;
            idx_q   <= '0;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        ST_DRAIN: state_q <= ST_IDLE;
        ST_REQ:   state_q <= ST_IDLE;
        ST_FLUSH: state_q <= ST_IDLE;
        default:  state_q <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    ctl_o          = '0;
    ctl_o.latch    = accept;
    ctl_o.tick_inc = accept && (command_i == CMD_TICK);
    ctl_o.scan     = (state_q == ST_SCAN);
    ctl_o.drain    = (state_q == ST_DRAIN);
    ctl_o.req      = (state_q == ST_REQ);
    ctl_o.flush    = (state_q == ST_FLUSH);
    ctl_o.idx      = idx_q;
  end

endmodule

@@ design/patt_dp.sv @@
// slot table, time counter and result register of the alarm timer table
`include "periodic_alarm_timer_table_core_defines.svh"

module patt_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  patt_pkg::req_t     req_i,
  input  patt_pkg::ctl_t     ctl_i,
  output logic               res_valid_o,
  output patt_pkg::res_t     res_o
);
  import patt_pkg::*;

  logic [TIME_W-1:0]   now_q;
  logic [TIME_W-1:0]   now_d;
  logic [SLOTS-1:0]    valid_q;
  logic [SLOTS-1:0]    valid_d;
  logic [CLIENT_W-1:0] client_q [SLOTS];
  logic [TAG_W-1:0]    tag_q    [SLOTS];
  logic [TIME_W-1:0]   expiry_q [SLOTS];
  logic [PERIOD_W-1:0] period_q [SLOTS];
  logic [CYC_W-1:0]    cycles_q [SLOTS];

  req_t                req_q;
  res_t                pend_q;
  logic                pend_vld_q;
  logic                pend_vld_d;
  logic [CNT_W-1:0]    cnt_q;
  logic [CNT_W-1:0]    cnt_d;
  res_t                res_q;
  logic                res_vld_q;
  logic                res_vld_d;

  // request decode
  logic [PERIOD_W-1:0] delay_eff;
  logic [TIME_W-1:0]   new_expiry;
  logic [PERIOD_W-1:0] new_period;
  logic [CYC_W-1:0]    new_cycles;
  logic                has_free;
  logic [IDX_W-1:0]    free_idx;

  // scan path
  logic [IDX_W-1:0]    idx;
  logic [TIME_W-1:0]   sel_exp;
  logic [PERIOD_W-1:0] sel_per;
  logic [CYC_W-1:0]    sel_cyc;
  logic                due;
  logic [TIME_W-1:0]   exp_from_old;
  logic [TIME_W-1:0]   exp_from_now;
  logic [TIME_W-1:0]   exp_next;

  assign delay_eff = (req_q.delay_ticks == '0) ? PERIOD_W'(1) : req_q.delay_ticks;

  always_comb begin
    new_expiry = time_add_sat(now_q, delay_eff);
    new_period = delay_eff;
    new_cycles = CYC_W'(1);
    case (req_q.command)
      CMD_CLOCK:  new_cycles = req_q.repeat_count;
      CMD_WAKEUP: begin
        new_expiry = req_q.wake_time;
        new_period = PERIOD_W'(1);
      end
      default:    ;
    endcase
  end

  // lowest free slot
  always_comb begin
    has_free = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        has_free = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  assign idx          = ctl_i.idx;
  assign sel_exp      = expiry_q[idx];
  assign sel_per      = period_q[idx];
  assign sel_cyc      = cycles_q[idx];
  assign due          = valid_q[idx] && (sel_exp <= now_q) &&
                        (cnt_q < CNT_W'(MAX_RESULTS));
  assign exp_from_old = time_add_sat(sel_exp, sel_per);
  assign exp_from_now = time_add_sat(now_q, sel_per);
  // fell behind: restart from now
  assign exp_next     = (exp_from_old < now_q) ? exp_from_now : exp_from_old;

  // control state next values
  always_comb begin
    now_d      = now_q;
    valid_d    = valid_q;
    pend_vld_d = pend_vld_q;
    cnt_d      = cnt_q;
    res_vld_d  = 1'b0;
    if (ctl_i.tick_inc) begin
      now_d = now_q + 1'b1;
    end
    if (ctl_i.latch) begin
      cnt_d      = '0;
      pend_vld_d = 1'b0;
    end
    if (ctl_i.scan && due) begin
      cnt_d      = cnt_q + 1'b1;
      pend_vld_d = 1'b1;
      res_vld_d  = pend_vld_q;
      if (sel_cyc == CYC_W'(1)) begin
        valid_d[idx] = 1'b0;
      end
    end
    if (ctl_i.drain) begin
      res_vld_d  = pend_vld_q;
      pend_vld_d = 1'b0;
    end
    if (ctl_i.req) begin
      res_vld_d = 1'b1;
      if (has_free) begin
        valid_d[free_idx] = 1'b1;
      end
    end
    if (ctl_i.flush) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (valid_q[i] && (client_q[i] == req_q.client_id)) begin
          valid_d[i] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q      <= '0;
      valid_q    <= '0;
      pend_vld_q <= 1'b0;
      cnt_q      <= '0;
      res_vld_q  <= 1'b0;
    end else begin
      now_q      <= now_d;
      valid_q    <= valid_d;
      pend_vld_q <= pend_vld_d;
      cnt_q      <= cnt_d;
      res_vld_q  <= res_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.latch) begin
      req_q <= req_i;
    end
    if (ctl_i.scan && due) begin
      res_q  <= '{kind: pend_q.kind, alarm_client: pend_q.alarm_client,
                  alarm_tag: pend_q.alarm_tag, last: 1'b0};
      pend_q <= '{kind: KIND_ALARM, alarm_client: client_q[idx],
                  alarm_tag: tag_q[idx], last: 1'b0};
      if (sel_cyc != CYC_W'(1)) begin
        expiry_q[idx] <= exp_next;
        if (sel_cyc > CYC_W'(1)) begin
          cycles_q[idx] <= sel_cyc - 1'b1;
        end
      end
    end
    if (ctl_i.drain) begin
      res_q <= '{kind: pend_q.kind, alarm_client: pend_q.alarm_client,
                 alarm_tag: pend_q.alarm_tag, last: 1'b1};
    end
    if (ctl_i.req) begin
      res_q <= '{kind: (has_free ? KIND_ACCEPT : KIND_FULL),
                 alarm_client: req_q.client_id, alarm_tag: req_q.tag, last: 1'b1};
      if (has_free) begin
        client_q[free_idx] <= req_q.client_id;
        tag_q[free_idx]    <= req_q.tag;
        expiry_q[free_idx] <= new_expiry;
        period_q[free_idx] <= new_period;
        cycles_q[free_idx] <= new_cycles;
      end
    end
  end

  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

  `PATT_ASSERT_IMPL(a_req_beat_is_last, clk_i, rst_ni,
                    res_vld_q && (res_q.kind != KIND_ALARM), res_q.last)
  `PATT_ASSERT_NEXT(a_accept_claims_slot, clk_i, rst_ni, ctl_i.req && has_free,
                    $countones(valid_q) == $past($countones(valid_q)) + 1)
  `PATT_ASSERT_NEVER(a_cnt_bound, clk_i, rst_ni, cnt_q > CNT_W'(MAX_RESULTS))
  `PATT_ASSERT_NEXT(a_full_keeps_table, clk_i, rst_ni, ctl_i.req && !has_free,
                    $stable(valid_q))

endmodule

@@ design/periodic_alarm_timer_table_core.sv @@
// top level of the periodic alarm timer table
//
//  channel   signals                    handshake
//  request   start, req_i, busy         beat taken when start && !busy
//  result    res_valid_o, res_o         one-cycle strobe, no back-pressure
//
// tick: accept cycle, one cycle per slot in the scan, drain cycle. delay, clock,
// wakeup, flush: accept cycle, then the request or flush state. an unknown
// command: accept cycle only. alarm beats trail the scan by one due slot; the
// final one, tagged last, is out in the cycle after the drain, and a request's
// reply in the cycle after the request state. reset (rst_ni low) empties the
// table and zeroes the time counter at once. results cannot be stalled.
module periodic_alarm_timer_table_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  patt_pkg::req_t     req_i,
  output logic               busy,
  output logic               res_valid_o,
  output patt_pkg::res_t     res_o
);
  import patt_pkg::*;

  ctl_t ctl;

  patt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .command_i (req_i.command),
    .busy      (busy),
    .ctl_o     (ctl)
  );

  patt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .ctl_i       (ctl),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

@@ verif/alarm_table_checker.sv @@
// checker for the alarm timer table: predicts every result beat and compares it
`timescale 1ns / 1ps

module alarm_table_checker (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             busy_i,
  input  patt_pkg::req_t   req_i,
  input  logic             res_valid_i,
  input  patt_pkg::res_t   res_i,
  output int               mismatches_o,
  output int               outstanding_o,
  output int               alarms_o,
  output int               accepts_o,
  output int               fulls_o
);

  import patt_pkg::*;

  logic [TIME_W-1:0]   clock_now;
  logic                slot_live  [SLOTS];
  logic [CLIENT_W-1:0] slot_owner [SLOTS];
  logic [TAG_W-1:0]    slot_word  [SLOTS];
  logic [TIME_W-1:0]   slot_due   [SLOTS];
  logic [PERIOD_W-1:0] slot_step  [SLOTS];
  logic [CYC_W-1:0]    slot_left  [SLOTS];

  res_t pending_beats[$];

  int mismatches = 0;
  int alarms     = 0;
  int accepts    = 0;
  int fulls      = 0;

  assign mismatches_o  = mismatches;
  assign outstanding_o = pending_beats.size();
  assign alarms_o      = alarms;
  assign accepts_o     = accepts;
  assign fulls_o       = fulls;

  function automatic logic [TIME_W-1:0] saturating_expiry(input logic [TIME_W-1:0]   t,
                                                          input logic [PERIOD_W-1:0] p);
    logic [TIME_W:0] sum;
    sum = {1'b0, t} + p;
    return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
  endfunction

  function automatic res_t make_beat(input kind_e k, input logic [CLIENT_W-1:0] owner,
                                     input logic [TAG_W-1:0] word);
    res_t beat;
    beat.kind         = k;
    beat.alarm_client = owner;
    beat.alarm_tag    = word;
    beat.last         = 1'b0;
    return beat;
  endfunction

  // lowest free slot wins; table full answers with the request's own client and tag
  function automatic res_t claim_slot(input logic [CLIENT_W-1:0] owner,
                                      input logic [TAG_W-1:0]    word,
                                      input logic [TIME_W-1:0]   due,
                                      input logic [PERIOD_W-1:0] step,
                                      input logic [CYC_W-1:0]    left);
    res_t beat;
    beat = make_beat(KIND_FULL, owner, word);
    for (int i = 0; i < SLOTS; i++) begin
      if (!slot_live[i]) begin
        slot_live[i]  = 1'b1;
        slot_owner[i] = owner;
        slot_word[i]  = word;
        slot_due[i]   = due;
        slot_step[i]  = step;
        slot_left[i]  = left;
        beat.kind     = KIND_ACCEPT;
        return beat;
      end
    end
    return beat;
  endfunction

  task automatic advance_table(input req_t r);
    logic [PERIOD_W-1:0] span;
    logic [TIME_W-1:0]   next_due;
    res_t                beats[$];
    span = (r.delay_ticks == '0) ? PERIOD_W'(1) : r.delay_ticks;
    case (r.command)
      CMD_TICK: begin
        clock_now = clock_now + 1'b1;
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_live[i] && slot_due[i] <= clock_now && beats.size() < MAX_RESULTS) begin
            beats.push_back(make_beat(KIND_ALARM, slot_owner[i], slot_word[i]));
            if (slot_left[i] == CYC_W'(1)) begin
              slot_live[i] = 1'b0;
            end else begin
              next_due = saturating_expiry(slot_due[i], slot_step[i]);
              // fell behind: restart the period from now
              if (next_due < clock_now) next_due = saturating_expiry(clock_now, slot_step[i]);
              slot_due[i] = next_due;
              if (slot_left[i] > CYC_W'(1)) slot_left[i] = slot_left[i] - 1'b1;
            end
          end
        end
      end
      CMD_DELAY: begin
        beats.push_back(claim_slot(r.client_id, r.tag, saturating_expiry(clock_now, span),
                                   span, CYC_W'(1)));
      end
      CMD_CLOCK: begin
        beats.push_back(claim_slot(r.client_id, r.tag, saturating_expiry(clock_now, span),
                                   span, r.repeat_count));
      end
      CMD_WAKEUP: begin
        beats.push_back(claim_slot(r.client_id, r.tag, r.wake_time, PERIOD_W'(1), CYC_W'(1)));
      end
      CMD_FLUSH: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_live[i] && slot_owner[i] == r.client_id) slot_live[i] = 1'b0;
        end
      end
      default: begin
      end
    endcase
    if (beats.size() > 0) beats[beats.size()-1].last = 1'b1;
    foreach (beats[k]) pending_beats.push_back(beats[k]);
  endtask

  function automatic void check_field(input string name, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      clock_now = '0;
      for (int i = 0; i < SLOTS; i++) slot_live[i] = 1'b0;
      pending_beats.delete();
    end else begin
      // result beats belong to earlier commands, so check before predicting
      if (res_valid_i) begin
        if (pending_beats.size() == 0) begin
          $error("result beat with nothing expected: kind %0d client 0x%0h tag 0x%0h",
                 res_i.kind, res_i.alarm_client, res_i.alarm_tag);
          mismatches++;
        end else begin
          want = pending_beats.pop_front();
          check_field("kind", want.kind, res_i.kind);
          check_field("alarm_client", want.alarm_client, res_i.alarm_client);
          check_field("alarm_tag", want.alarm_tag, res_i.alarm_tag);
          check_field("last", want.last, res_i.last);
          case (want.kind)
            KIND_ALARM:  alarms++;
            KIND_ACCEPT: accepts++;
            default:     fulls++;
          endcase
        end
      end
      if (start_i && !busy_i) advance_table(req_i);
    end
  end

endmodule

@@ verif/tb_top.sv @@
// testbench top for the alarm timer table: stimulus, reset, clock and verdict
`timescale 1ns / 1ps

module tb_top;

  import patt_pkg::*;

  localparam logic [2:0]     CMD_FIRST_UNUSED = 3'd5;
  localparam int             RANDOM_ITEMS     = 205;
  localparam int             CALM_TAIL        = 40;
  localparam int             SETTLE_CYCLES    = 40;
  localparam logic [CLIENT_W-1:0] CLIENT_POOL [4] = '{8'h00, 8'hff, 8'h3c, 8'hc3};

  logic clk_i;
  logic rst_ni;
  logic start;
  req_t req;
  logic busy;
  logic res_valid;
  res_t res;

  int mismatches;
  int outstanding;
  int alarms;
  int accepts;
  int fulls;

  logic [TIME_W-1:0] ticks_sent;
  int n_ticks;
  int n_requests;
  int n_flushes;
  int n_ignored;

  periodic_alarm_timer_table_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .req_i       (req),
    .busy        (busy),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  alarm_table_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .req_i         (req),
    .res_valid_i   (res_valid),
    .res_i         (res),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding),
    .alarms_o      (alarms),
    .accepts_o     (accepts),
    .fulls_o       (fulls)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("periodic_alarm_timer_table_core: mismatch");
    $finish;
  end

  function automatic req_t make_item(input logic [2:0] cmd, input logic [CLIENT_W-1:0] who,
                                     input logic [PERIOD_W-1:0] delay,
                                     input logic [CYC_W-1:0] reps,
                                     input logic [TIME_W-1:0] wake,
                                     input logic [TAG_W-1:0] word);
    req_t r;
    r.command      = cmd;
    r.client_id    = who;
    r.delay_ticks  = delay;
    r.repeat_count = reps;
    r.wake_time    = wake;
    r.tag          = word;
    return r;
  endfunction

  function automatic req_t random_item();
    req_t           r;
    logic [127:0]   raw;
    int             pick;
    logic [CLIENT_W-1:0] pooled;
    raw    = {$urandom, $urandom, $urandom, $urandom};
    r      = raw[$bits(req_t)-1:0];
    pick   = $urandom_range(0, 99);
    pooled = CLIENT_POOL[$urandom_range(0, 3)];
    if (pick < 45) begin
      r.command = CMD_TICK;
    end else if (pick < 60) begin
      r.command = CMD_DELAY;
      if ($urandom_range(0, 9) == 0) begin
        r.client_id = pooled;
      end else begin
        r.delay_ticks = PERIOD_W'($urandom_range(0, 6));
        r.client_id   = ($urandom_range(0, 3) == 0) ? CLIENT_W'($urandom) : pooled;
      end
    end else if (pick < 72) begin
      // periodic slots stay with pool clients so flushes can reclaim them
      r.command   = CMD_CLOCK;
      r.client_id = pooled;
      if ($urandom_range(0, 9) != 0) r.delay_ticks = PERIOD_W'($urandom_range(0, 5));
      if ($urandom_range(0, 9) < 6) r.repeat_count = CYC_W'($urandom_range(0, 3));
    end else if (pick < 84) begin
      r.command = CMD_WAKEUP;
      if ($urandom_range(0, 3) == 0) begin
        r.client_id = pooled;
      end else begin
        r.client_id = ($urandom_range(0, 3) == 0) ? CLIENT_W'($urandom) : pooled;
        if ($urandom_range(0, 4) == 0)
          r.wake_time = TIME_W'($urandom_range(0, int'(ticks_sent)));
        else
          r.wake_time = ticks_sent + TIME_W'($urandom_range(0, 6));
      end
    end else if (pick < 96) begin
      r.command   = CMD_FLUSH;
      r.client_id = ($urandom_range(0, 6) == 0) ? CLIENT_W'($urandom) : pooled;
    end else begin
      r.command = CMD_FIRST_UNUSED + 3'($urandom_range(0, 2));
    end
    return r;
  endfunction

  // entered and left at a falling edge
  task automatic idle_burst(input int cycles);
    logic [127:0] raw;
    raw   = {$urandom, $urandom, $urandom, $urandom};
    start <= 1'b0;
    req   <= raw[$bits(req_t)-1:0];
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic send_item(input req_t r, input bit may_idle);
    if (may_idle && $urandom_range(0, 2) == 0) idle_burst($urandom_range(1, 15));
    start <= 1'b1;
    req   <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    case (r.command)
      CMD_TICK: begin
        n_ticks++;
        ticks_sent = ticks_sent + 1'b1;
      end
      CMD_DELAY, CMD_CLOCK, CMD_WAKEUP: n_requests++;
      CMD_FLUSH: n_flushes++;
      default: n_ignored++;
    endcase
    @(negedge clk_i);
  endtask

  task automatic wait_for_quiet(input int extra);
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (extra) @(negedge clk_i);
  endtask

  initial begin
    rst_ni     = 1'b0;
    start      = 1'b0;
    req        = '0;
    ticks_sent = '0;
    n_ticks    = 0;
    n_requests = 0;
    n_flushes  = 0;
    n_ignored  = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty table, unknown codes, zero delay, past wakeup, repeats, full table
    send_item(make_item(CMD_TICK, 8'h00, '0, '0, '0, '0), 1'b1);
    send_item(make_item(CMD_FIRST_UNUSED, 8'hff, '1, '1, '1, '1), 1'b1);
    send_item(make_item(CMD_FIRST_UNUSED + 3'd1, 8'h00, '0, '0, '0, '0), 1'b1);
    send_item(make_item(CMD_FIRST_UNUSED + 3'd2, 8'h3c, '1, '0, '1, '0), 1'b1);
    send_item(make_item(CMD_FLUSH, 8'h00, '0, '0, '0, '0), 1'b1);
    send_item(make_item(CMD_DELAY, 8'hc3, '0, '1, '1, 16'hffff), 1'b1);
    send_item(make_item(CMD_WAKEUP, 8'hff, '1, '1, '0, 16'h0000), 1'b1);
    send_item(make_item(CMD_TICK, 8'h00, '0, '0, '0, '0), 1'b1);
    send_item(make_item(CMD_CLOCK, 8'h00, 32'd1, 16'd0, '0, 16'h1234), 1'b1);
    send_item(make_item(CMD_CLOCK, 8'h3c, 32'd2, 16'd3, '0, 16'hedcb), 1'b1);
    repeat (3) send_item(make_item(CMD_TICK, 8'hff, '1, '1, '1, '1), 1'b1);
    send_item(make_item(CMD_DELAY, 8'hff, 32'hffff_ffff, '0, '1, 16'h5a5a), 1'b1);
    send_item(make_item(CMD_WAKEUP, 8'hc3, '0, '0, 40'hff_ffff_ffff, 16'ha5a5), 1'b1);
    // fills the table and then runs into the full reply
    for (int i = 0; i < 14; i++)
      send_item(make_item(CMD_CLOCK, 8'h3c, 32'hffff_fff0, 16'hffff, '0, TAG_W'(i)), 1'b1);
    send_item(make_item(CMD_TICK, 8'h00, '0, '0, '0, '0), 1'b1);
    foreach (CLIENT_POOL[k])
      send_item(make_item(CMD_FLUSH, CLIENT_POOL[k], '0, '0, '0, '0), 1'b1);
    wait_for_quiet(SETTLE_CYCLES);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) wait_for_quiet(SETTLE_CYCLES);
      send_item(random_item(), i < RANDOM_ITEMS - CALM_TAIL);
    end

    wait_for_quiet(SETTLE_CYCLES);
    if (outstanding != 0) $error("%0d expected result beats never arrived", outstanding);
    $display("ran %0d commands: %0d ticks, %0d requests, %0d flushes, %0d unknown codes",
             n_ticks + n_requests + n_flushes + n_ignored, n_ticks, n_requests, n_flushes,
             n_ignored);
    $display("compared %0d alarm, %0d accepted and %0d table-full beats",
             alarms, accepts, fulls);
    if (mismatches == 0 && outstanding == 0) begin
      $display("periodic_alarm_timer_table_core: match");
    end else begin
      $display("periodic_alarm_timer_table_core: mismatch");
    end
    $finish;
  end

endmodule
